/* rtl/nvrc_pkg.sv */
// Package: shared types and constants for the NV21 crop block.
`default_nettype none
package nvrc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SRC_WIDTH   = 3'd0,
    REG_SRC_HEIGHT  = 3'd1,
    REG_ROI_LEFT    = 3'd2,
    REG_ROI_TOP     = 3'd3,
    REG_CROP_WIDTH  = 3'd4,
    REG_CROP_HEIGHT = 3'd5
  } reg_idx_t;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 13;
  localparam int DimW     = 13;
  localparam int OffW     = 12;

  // Result queue depth between classifier and output
  localparam int QDepth = 4;
  localparam int QAddrW = $clog2(QDepth);

  typedef struct packed {
    logic [DimW-1:0] src_width;
    logic [DimW-1:0] src_height;
    logic [OffW-1:0] roi_left;
    logic [OffW-1:0] roi_top;
    logic [DimW-1:0] crop_width;
    logic [DimW-1:0] crop_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       frame_last;
    logic       geometry_error;
  } res_item_t;

endpackage
`default_nettype wire

/* rtl/nv21_roi_crop.sv */
// Each kept beat is written into the result queue as it is accepted.
// Throughput: one source beat per cycle; in_full rises only when the 4-entry result
//   queue is full, which takes cycles without a pop; a pop there frees a slot next cycle.
// Reset (rst_n low, synchronous): registers return to 640x480 source, 320x240 crop at
//   the origin; the raster position returns to the first luma byte; the queue empties.
// Top level: NV21 region-of-interest crop with configuration registers.
`default_nettype none
module nv21_roi_crop #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [nvrc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [nvrc_pkg::CfgDataW-1:0] cfg_wdata,
  // source beats
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [7:0]                    in_source_byte,
  // result beats
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [7:0]                         out_pixel_byte,
  output logic                               out_frame_last,
  output logic                               out_geometry_error
);
  import nvrc_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  res_item_t wr_item, rd_item;
  logic      wr_en, in_acc, q_full, q_empty;

  // Register writes; an index past the list is ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:   cfg_nxt.src_width   = cfg_wdata[DimW-1:0];
        REG_SRC_HEIGHT:  cfg_nxt.src_height  = cfg_wdata[DimW-1:0];
        REG_ROI_LEFT:    cfg_nxt.roi_left    = cfg_wdata[OffW-1:0];
        REG_ROI_TOP:     cfg_nxt.roi_top     = cfg_wdata[OffW-1:0];
        REG_CROP_WIDTH:  cfg_nxt.crop_width  = cfg_wdata[DimW-1:0];
        REG_CROP_HEIGHT: cfg_nxt.crop_height = cfg_wdata[DimW-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width   <= DimW'(640);
      cfg_r.src_height  <= DimW'(480);
      cfg_r.roi_left    <= '0;
      cfg_r.roi_top     <= '0;
      cfg_r.crop_width  <= DimW'(320);
      cfg_r.crop_height <= DimW'(240);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Take a beat whenever the queue has room; the front writes at most one result.
  assign in_full = q_full;
  assign in_acc  = in_push && !q_full;

  nvrc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_acc  (in_acc),
    .in_byte (in_source_byte),
    .wr_en   (wr_en),
    .wr_item (wr_item)
  );

  nvrc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_item (wr_item),
    .rd_en   (out_pop),
    .rd_item (rd_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Present the oldest result
  assign out_empty          = q_empty;
  assign out_pixel_byte     = rd_item.pixel_byte;
  assign out_frame_last     = rd_item.frame_last;
  assign out_geometry_error = rd_item.geometry_error;

`ifndef SYNTHESIS
  a_err_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_geometry_error) |-> (out_pixel_byte == 8'd0 && !out_frame_last))
    else $error("error result carries data");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_full && !out_pop) |=> in_full)
    else $error("queue drained without a pop");
  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_we |=> $stable(cfg_r))
    else $error("register changed without a write");
`endif

endmodule
`default_nettype wire

/* rtl/nvrc_front.sv */
// Front part: frame position counters and keep/drop classification of each beat.
`default_nettype none
module nvrc_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  nvrc_pkg::cfg_t          cfg,
  input  wire logic               in_acc,
  input  wire logic [7:0]         in_byte,
  output logic                    wr_en,
  output nvrc_pkg::res_item_t     wr_item
);
  import nvrc_pkg::*;

  localparam int CW  = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RW  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int MW  = (CW > RW) ? CW : RW;
  localparam int DW  = ((MW > DimW) ? MW : DimW) + 2;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          chroma_r, chroma_nxt;

  logic [DW-1:0] sw, sh, maxw, maxh, ew, eh, limit;
  logic [DW-1:0] left, top, cwid, chgt, rfirst, rcount, rend, cend;
  logic [DW-1:0] colx, rowx, col_inc, row_inc;
  logic          bad, row_in, col_in, last;

  always_comb begin
    sw   = DW'(cfg.src_width);
    sh   = DW'(cfg.src_height);
    maxw = DW'(MAX_WIDTH);
    maxh = DW'(MAX_HEIGHT);
    ew   = (sw < DW'(2)) ? DW'(2) : ((sw > maxw) ? maxw : sw);
    eh   = (sh < DW'(2)) ? DW'(2) : ((sh > maxh) ? maxh : sh);
    left = DW'({cfg.roi_left[OffW-1:1], 1'b0});
    top  = DW'({cfg.roi_top[OffW-1:1], 1'b0});
    cwid = DW'(cfg.crop_width);
    chgt = DW'(cfg.crop_height);
    cend = left + cwid;
    bad  = (sw < DW'(2)) || (sw > maxw) || (sh < DW'(2)) || (sh > maxh) ||
           cfg.crop_width[0] || cfg.crop_height[0] ||
           (cend > sw) || ((top + chgt) > sh);
    rfirst = chroma_r ? (top >> 1) : top;
    rcount = chroma_r ? (chgt >> 1) : chgt;
    rend   = rfirst + rcount;
    colx   = DW'(col_r);
    rowx   = DW'(row_r);
    row_in = (rowx >= rfirst) && (rowx < rend);
    col_in = (colx >= left) && (colx < cend);
    last   = chroma_r && (rowx == rend - DW'(1)) && (colx == cend - DW'(1));
  end

  // Classify the beat
  always_comb begin
    wr_en   = 1'b0;
    wr_item = '0;
    if (in_acc) begin
      if (bad) begin
        if ((col_r == '0) && (row_r == '0) && !chroma_r) begin
          wr_en                  = 1'b1;
          wr_item.geometry_error = 1'b1;
        end
      end else if (row_in && col_in) begin
        wr_en              = 1'b1;
        wr_item.pixel_byte = in_byte;
        wr_item.frame_last = last;
      end
    end
  end

  // Advance the raster position
  always_comb begin
    col_inc    = colx + DW'(1);
    row_inc    = rowx + DW'(1);
    limit      = chroma_r ? (eh >> 1) : eh;
    col_nxt    = col_r;
    row_nxt    = row_r;
    chroma_nxt = chroma_r;
    if (in_acc) begin
      if (col_inc >= ew) begin
        col_nxt = '0;
        if (row_inc >= limit) begin
          row_nxt    = '0;
          chroma_nxt = !chroma_r;
        end else begin
          row_nxt = row_inc[RW-1:0];
        end
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      chroma_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      chroma_r <= chroma_nxt;
    end
  end

`ifndef SYNTHESIS
  a_err_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && wr_item.geometry_error) |-> (col_r == '0 && row_r == '0 && !chroma_r))
    else $error("error result away from frame start");
  a_no_beat_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> in_acc)
    else $error("result without input beat");
  a_last_in_chroma: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && wr_item.frame_last) |-> (chroma_r && !wr_item.geometry_error))
    else $error("frame_last outside chroma plane");
  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && chroma_r != chroma_nxt) |-> (col_nxt == '0 && row_nxt == '0))
    else $error("plane switch without position wrap");
`endif

endmodule
`default_nettype wire

/* rtl/nvrc_queue.sv */
// Back part: short result queue that presents the oldest result to the output side.
`default_nettype none
module nvrc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  nvrc_pkg::res_item_t wr_item,
  input  wire logic           rd_en,
  output nvrc_pkg::res_item_t rd_item,
  output logic                full,
  output logic                empty
);
  import nvrc_pkg::*;

  res_item_t         mem [QDepth];
  logic [QAddrW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [QAddrW:0]   cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign full    = (cnt_r == (QAddrW+1)'(QDepth));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = mem[rptr_r];

  always_comb begin
    wptr_nxt = do_wr ? wptr_r + QAddrW'(1) : wptr_r;
    rptr_nxt = do_rd ? rptr_r + QAddrW'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + (QAddrW+1)'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - (QAddrW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAddrW+1)'(QDepth))
    else $error("queue count overflow");
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("result written into full queue");
  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> (cnt_r == $past(cnt_r) + (QAddrW+1)'(1)))
    else $error("queue count did not advance on write");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wptr_r - rptr_r) == cnt_r[QAddrW-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

/* test/nv21_crop_checker.sv */
// Checker for the NV21 crop block: tracks the raster position, predicts kept bytes, compares.
module nv21_crop_checker import nvrc_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_push,
  input  logic                in_full,
  input  logic [7:0]          in_source_byte,
  input  logic                out_empty,
  input  logic                out_pop,
  input  logic [7:0]          out_pixel_byte,
  input  logic                out_frame_last,
  input  logic                out_geometry_error,
  output int                  fail_count,
  output int                  pending,
  output int                  results_checked,
  output int                  error_results,
  output int                  frame_ends
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DimW-1:0] src_w, src_h, crop_w, crop_h;
  logic [OffW-1:0] roi_l, roi_t;
  int col_pos, row_pos;
  bit in_vu_plane;
  res_item_t crop_expect_q[$];
  int n_fail, n_checked, n_errors, n_lasts;

  // Work out what one source byte yields, then advance the raster position.
  task automatic predict_crop(input logic [7:0] src_byte);
    int sw, sh, left, top, cw, ch, ew, eh, rfirst, rcount;
    bit bad, last;
    sw = src_w;
    sh = src_h;
    cw = crop_w;
    ch = crop_h;
    left = int'(roi_l) & ~1;
    top  = int'(roi_t) & ~1;
    ew = (sw < 2) ? 2 : (sw > MAX_WIDTH ? MAX_WIDTH : sw);
    eh = (sh < 2) ? 2 : (sh > MAX_HEIGHT ? MAX_HEIGHT : sh);
    bad = sw < 2 || sw > MAX_WIDTH || sh < 2 || sh > MAX_HEIGHT || cw[0] || ch[0] ||
          left + cw > sw || top + ch > sh;
    if (bad) begin
      if (col_pos == 0 && row_pos == 0 && !in_vu_plane)
        crop_expect_q.push_back('{pixel_byte: 8'h00, frame_last: 1'b0, geometry_error: 1'b1});
    end else begin
      rfirst = in_vu_plane ? top / 2 : top;
      rcount = in_vu_plane ? ch / 2 : ch;
      if (row_pos >= rfirst && row_pos < rfirst + rcount &&
          col_pos >= left && col_pos < left + cw) begin
        last = in_vu_plane && row_pos == rfirst + rcount - 1 && col_pos == left + cw - 1;
        crop_expect_q.push_back('{pixel_byte: src_byte, frame_last: last,
                                  geometry_error: 1'b0});
      end
    end
    col_pos++;
    if (col_pos >= ew) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= (in_vu_plane ? eh / 2 : eh)) begin
        row_pos = 0;
        in_vu_plane = !in_vu_plane;
      end
    end
  endtask

  always @(posedge clk) begin
    res_item_t want;
    if (!rst_n) begin
      src_w = 13'd640;
      src_h = 13'd480;
      roi_l = '0;
      roi_t = '0;
      crop_w = 13'd320;
      crop_h = 13'd240;
      col_pos = 0;
      row_pos = 0;
      in_vu_plane = 1'b0;
      crop_expect_q.delete();
    end else begin
      // Compare the popped beat first: a byte pushed at this edge is not yet in the queue.
      if (out_pop && !out_empty) begin
        if (crop_expect_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("unexpected result: byte %02h last %0b err %0b", out_pixel_byte,
                     out_frame_last, out_geometry_error);
        end else begin
          want = crop_expect_q.pop_front();
          n_checked++;
          if (want.geometry_error) n_errors++;
          if (want.frame_last) n_lasts++;
          if (out_pixel_byte !== want.pixel_byte || out_frame_last !== want.frame_last ||
              out_geometry_error !== want.geometry_error) begin
            n_fail++;
            if (n_fail <= 10)
              $display("mismatch: expected byte %02h last %0b err %0b, got %02h %0b %0b",
                       want.pixel_byte, want.frame_last, want.geometry_error,
                       out_pixel_byte, out_frame_last, out_geometry_error);
          end
        end
      end
      // A beat taken at this edge still sees the registers from before the edge.
      if (in_push && !in_full) predict_crop(in_source_byte);
      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_WIDTH:   src_w  = cfg_wdata[DimW-1:0];
          REG_SRC_HEIGHT:  src_h  = cfg_wdata[DimW-1:0];
          REG_ROI_LEFT:    roi_l  = cfg_wdata[OffW-1:0];
          REG_ROI_TOP:     roi_t  = cfg_wdata[OffW-1:0];
          REG_CROP_WIDTH:  crop_w = cfg_wdata[DimW-1:0];
          REG_CROP_HEIGHT: crop_h = cfg_wdata[DimW-1:0];
          default: ;
        endcase
      end
    end
    fail_count      <= n_fail;
    pending         <= crop_expect_q.size();
    results_checked <= n_checked;
    error_results   <= n_errors;
    frame_ends      <= n_lasts;
  end

endmodule

/* test/tb.sv */
// Testbench top: drives source frames and crop geometries into the NV21 crop block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nvrc_pkg::*;

  localparam int MAX_W       = 4096;
  localparam int MAX_H       = 4096;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_BEATS = 850;
  localparam int CALM_AFTER   = 650;
  // Register indexes that decode to nothing; writes there must leave the geometry alone
  localparam logic [CfgIdxW-1:0] IDX_SPARE0 = 3'd6;
  localparam logic [CfgIdxW-1:0] IDX_SPARE1 = 3'd7;

  typedef struct {
    int sw, sh, left, top, cw, ch;
  } geom_t;

  typedef enum {
    FLAW_NONE, FLAW_ODD_W, FLAW_ODD_H, FLAW_OVER_W, FLAW_OVER_H, FLAW_TINY_W, FLAW_TINY_H
  } flaw_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_push = 1'b0;
  logic                in_full;
  logic [7:0]          in_source_byte = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  logic [7:0]          out_pixel_byte;
  logic                out_frame_last;
  logic                out_geometry_error;

  int fail_count, pending, results_checked, error_results, frame_ends;

  // Stimulus controls shared with the pop side
  bit pop_idle = 1'b1;
  int stall_req = 0;
  bit push_idle = 1'b1;
  int beats_sent = 0;
  int geoms_applied = 0;
  int cycle_count = 0;

  nv21_roi_crop #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_source_byte    (in_source_byte),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_pixel_byte    (out_pixel_byte),
    .out_frame_last    (out_frame_last),
    .out_geometry_error(out_geometry_error)
  );

  nv21_crop_checker #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_source_byte    (in_source_byte),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_pixel_byte    (out_pixel_byte),
    .out_frame_last    (out_frame_last),
    .out_geometry_error(out_geometry_error),
    .fail_count        (fail_count),
    .pending           (pending),
    .results_checked   (results_checked),
    .error_results     (error_results),
    .frame_ends        (frame_ends)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block wedges or drops a result
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Pop side: random idle bursts, plus a long hold-off on request.
  // The hold-off is counted here so the sender keeps pushing and the block backs up.
  always @(posedge clk) begin
    int pop_gap, stall_left, stall_seen;
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_gap = 0;
      stall_left = 0;
      stall_seen = 0;
    end else begin
      if (stall_seen != stall_req) begin
        stall_seen = stall_req;
        stall_left = 120;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else if (pop_idle && $urandom_range(0, 9) == 0) begin
        pop_gap = $urandom_range(0, 6);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  function automatic geom_t make_geom(input int sw, sh, left, top, cw, ch);
    geom_t g;
    g.sw = sw;
    g.sh = sh;
    g.left = left;
    g.top = top;
    g.cw = cw;
    g.ch = ch;
    return g;
  endfunction

  // Beats in one source frame: full luma plane plus the VU plane at half height.
  // Out-of-range source sizes are counted at their clamped value.
  function automatic int frame_len(input geom_t g);
    int ew, eh;
    ew = (g.sw < 2) ? 2 : (g.sw > MAX_W ? MAX_W : g.sw);
    eh = (g.sh < 2) ? 2 : (g.sh > MAX_H ? MAX_H : g.sh);
    return ew * eh + ew * (eh / 2);
  endfunction

  // Drive a register write with the enable, then drop the enable before returning.
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CfgDataW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Advance until every predicted result has been popped.
  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic apply_geom(input geom_t g);
    wait_drained();
    // let the pipeline settle on beats that produce nothing
    repeat (4) @(posedge clk);
    cfg_write(REG_SRC_WIDTH, g.sw);
    cfg_write(REG_SRC_HEIGHT, g.sh);
    cfg_write(REG_ROI_LEFT, g.left);
    cfg_write(REG_ROI_TOP, g.top);
    cfg_write(REG_CROP_WIDTH, g.cw);
    cfg_write(REG_CROP_HEIGHT, g.ch);
    geoms_applied++;
  endtask

  // Push n random source beats with optional idle bursts, then drop push before returning.
  task automatic send_bytes(input int n);
    for (int i = 0; i < n; i++) begin
      if (push_idle && $urandom_range(0, 7) == 0) begin
        in_push <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      in_push <= 1'b1;
      in_source_byte <= 8'($urandom_range(0, 255));
      @(posedge clk);
      while (in_full) @(posedge clk);
      beats_sent++;
    end
    in_push <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_frames(input geom_t g, input int frames);
    push_idle = $urandom_range(0, 2) != 0;
    pop_idle <= $urandom_range(0, 2) != 0;
    apply_geom(g);
    send_bytes(frames * frame_len(g));
  endtask

  // Rejected geometry on a frame that clamps to a huge size: take only the error beat,
  // then shrink the source to 2x2 with an empty crop. From luma row 0, column 1 that
  // needs 5 more beats (end of row 0, row 1, one VU row) to reach the frame start.
  task automatic run_rejected(input geom_t g);
    apply_geom(g);
    send_bytes(1);
    apply_geom(make_geom(2, 2, 0, 0, 0, 0));
    send_bytes(5);
  endtask

  initial begin
    geom_t g;
    flaw_t flaw;
    int n, part, random_beats;
    bit stalled;
    random_beats = 0;
    stalled = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry: 640x480 source, 320x240 crop at the origin, so the first
    // beats of the frame are all kept.
    send_bytes(4);

    // Shrink the source mid-row. Column 4 is already past the new width of 4, so
    // the next beat wraps to luma row 1; 4 + 4 more beats close the 4x2 frame.
    apply_geom(make_geom(4, 2, 0, 0, 4, 2));
    send_bytes(9);

    // Swap the crop window exactly at the luma/chroma boundary.
    apply_geom(make_geom(8, 4, 2, 2, 4, 2));
    send_bytes(32);
    apply_geom(make_geom(8, 4, 0, 0, 8, 4));
    send_bytes(16);

    // Shrink the height mid-luma: row 6 is past the new limit of 4, so the next
    // row end jumps straight into the chroma plane (4 + 8 beats to frame end).
    apply_geom(make_geom(4, 8, 1, 3, 2, 2));
    send_bytes(24);
    apply_geom(make_geom(4, 4, 0, 0, 4, 4));
    send_bytes(12);

    // Wide frame kept whole while the pop side holds off, so the queue fills up
    g = make_geom(32, 2, 0, 0, 32, 2);
    apply_geom(g);
    stall_req <= stall_req + 1;
    stalled = 1'b1;
    send_bytes(frame_len(g));

    // Wide and tall frames, crop pinned to the far edges
    run_frames(make_geom(32, 2, 31, 0, 2, 2), 1);
    run_frames(make_geom(2, 32, 1, 31, 2, 2), 1);
    run_frames(make_geom(2, 32, 0, 0, 2, 32), 1);

    // All-ones registers but one zero source size: oversize source, odd crop, window far past the edge
    run_rejected(make_geom(8191, 0, 4095, 4095, 8191, 8191));
    run_rejected(make_geom(0, 8191, 4095, 4095, 8191, 8191));
    // Source below the minimum size
    run_frames(make_geom(0, 0, 0, 0, 0, 0), 1);
    run_frames(make_geom(1, 1, 0, 0, 0, 0), 1);
    // Odd crop width, odd crop height
    run_frames(make_geom(6, 4, 0, 0, 3, 2), 1);
    run_frames(make_geom(6, 4, 0, 0, 2, 3), 1);
    // Window past the right edge, then past the bottom edge
    run_frames(make_geom(6, 4, 2, 0, 6, 2), 1);
    run_frames(make_geom(6, 4, 0, 2, 2, 4), 1);
    // Odd offsets round down and the window then fits exactly at the corner
    run_frames(make_geom(6, 4, 3, 3, 4, 2), 1);
    // Empty crops: nothing kept, no error
    run_frames(make_geom(6, 4, 0, 0, 0, 2), 1);
    run_frames(make_geom(6, 4, 0, 0, 4, 0), 1);
    // Odd source height: chroma plane has floor(h/2) rows
    g = make_geom(6, 5, 0, 0, 6, 4);
    run_frames(g, 1);

    // Writes to undecoded indexes must not disturb the geometry
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_write(IDX_SPARE0, 13'h1FFF);
    cfg_write(IDX_SPARE1, 13'h0AAA);
    send_bytes(frame_len(g));

    // Random geometries on small frames; most are legal, some carry one flaw.
    while (random_beats < RANDOM_BEATS) begin
      if (random_beats >= CALM_AFTER) begin
        // closing stretch runs at full rate on both sides
        push_idle = 1'b0;
        pop_idle <= 1'b0;
      end else begin
        push_idle = $urandom_range(0, 3) != 0;
        pop_idle <= $urandom_range(0, 3) != 0;
      end

      g.sw = $urandom_range(2, 12);
      g.sh = $urandom_range(2, 8);
      g.cw = 2 * $urandom_range(0, g.sw / 2);
      g.left = $urandom_range(0, g.sw - g.cw);
      g.ch = 2 * $urandom_range(0, g.sh / 2);
      g.top = $urandom_range(0, g.sh - g.ch);

      if ($urandom_range(0, 9) < 8) flaw = FLAW_NONE;
      else flaw = flaw_t'($urandom_range(FLAW_ODD_W, FLAW_TINY_H));
      case (flaw)
        FLAW_ODD_W:  g.cw = g.cw | 1;
        FLAW_ODD_H:  g.ch = g.ch | 1;
        FLAW_OVER_W: g.cw = ((g.sw - (g.left & ~1)) / 2 + 1) * 2;
        FLAW_OVER_H: g.ch = ((g.sh - (g.top & ~1)) / 2 + 1) * 2;
        FLAW_TINY_W: g.sw = $urandom_range(0, 1);
        FLAW_TINY_H: g.sh = $urandom_range(0, 1);
        default: ;
      endcase

      apply_geom(g);
      // a rejected frame yields one result, so keep those to a single frame
      n = (flaw == FLAW_NONE) ? $urandom_range(1, 3) * frame_len(g) : frame_len(g);

      // Stall the pop side for a long stretch while this frame streams in
      if (random_beats < CALM_AFTER && flaw == FLAW_NONE && g.cw * g.ch >= 8 &&
          (!stalled || $urandom_range(0, 15) == 0)) begin
        stall_req <= stall_req + 1;
        stalled = 1'b1;
      end

      if ($urandom_range(0, 5) == 0) begin
        // pause mid-frame until every expected result is out
        part = $urandom_range(1, n - 1);
        send_bytes(part);
        wait_drained();
        send_bytes(n - part);
      end else begin
        send_bytes(n);
      end
      random_beats += n;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d source beats over %0d geometries: %0d results checked,",
             beats_sent, geoms_applied, results_checked);
    $display("  %0d geometry rejections and %0d cropped frame ends among them.",
             error_results, frame_ends);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
